// ===== rtl/core/tpps_pkg.sv =====
package tpps_pkg;

	localparam int REQ_W         = 28;
	localparam int FRAC_BITS     = 4;
	localparam int TARGET_W      = REQ_W + FRAC_BITS;
	localparam int CLK_W         = 16;
	localparam int MAX_SHIFT     = 8;
	localparam int TICK_W        = CLK_W + MAX_SHIFT;
	localparam int NUM_PRESCALER = 8;
	localparam int IDX_W         = 3;
	localparam int PR_W          = 16;
	localparam int ERROR_SHIFT   = 5;
	localparam int CNT_W         = $clog2(TARGET_W);

	localparam logic [CLK_W-1:0] CLK_PERIOD_RESET = 16'd200;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_FIT    = 2'd1,
		STATUS_ERR_LIMIT = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    k_inc;
		logic    div_start;
		logic    div_step;
		logic    finish;
		status_t code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fits;
		logic last_k;
		logic div_last;
		logic accept;
	} dp_sts_t;

	// prescaler set 1,2,4,8,16,32,64,256 as left shifts
	function automatic logic [3:0] prescale_shift(input logic [IDX_W-1:0] idx);
		logic [3:0] sh;
		begin
			unique case (idx)
				3'd0:    sh = 4'd0;
				3'd1:    sh = 4'd1;
				3'd2:    sh = 4'd2;
				3'd3:    sh = 4'd3;
				3'd4:    sh = 4'd4;
				3'd5:    sh = 4'd5;
				3'd6:    sh = 4'd6;
				default: sh = 4'd8;
			endcase
			return sh;
		end
	endfunction

endpackage

// ===== rtl/core/tpps_ctrl.sv =====
module tpps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tpps_pkg::dp_sts_t sts,
	output tpps_pkg::dp_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import tpps_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_EVAL
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		cmd.code = STATUS_OK;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// smallest prescaler whose period register reaches the target
				if (sts.fits) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (sts.last_k) begin
					cmd.finish = 1'b1;
					cmd.code   = STATUS_NO_FIT;
					state_d    = ST_IDLE;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.accept) begin
					cmd.finish = 1'b1;
					cmd.code   = STATUS_OK;
					state_d    = ST_IDLE;
				end else if (sts.last_k) begin
					cmd.finish = 1'b1;
					cmd.code   = STATUS_ERR_LIMIT;
					state_d    = ST_IDLE;
				end else begin
					cmd.k_inc     = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= cmd.finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/core/tpps_dp.sv =====
module tpps_dp #(
	parameter int TIMER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpps_pkg::dp_cmd_t             cmd,
	output tpps_pkg::dp_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [tpps_pkg::CLK_W-1:0]    cfg_data,
	input  logic [tpps_pkg::REQ_W-1:0]    desired_period_ns,
	output logic [1:0]                    status,
	output logic [tpps_pkg::IDX_W-1:0]    prescale_idx,
	output logic [tpps_pkg::PR_W-1:0]     period_register
);
	import tpps_pkg::*;

	logic [CLK_W-1:0]    clk_period_q;
	logic [TARGET_W-1:0] target_q;
	logic [IDX_W-1:0]    k_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TARGET_W-1:0] dvd_q;
	logic [TARGET_W-1:0] quo_q;
	logic [TICK_W-1:0]   rem_q;
	logic [1:0]          status_q;
	logic [IDX_W-1:0]    index_q;
	logic [PR_W-1:0]     period_q;

	logic [TICK_W-1:0]   tick;
	logic [TARGET_W-1:0] reach;
	logic [TICK_W:0]     rem_sh;
	logic [TICK_W:0]     rem_diff;
	logic                rem_ge;
	logic [TICK_W-1:0]   err_up;
	logic [TICK_W-1:0]   err;
	logic                pick_upper;
	logic [TARGET_W-1:0] limit;
	logic [PR_W-1:0]     chosen;

	assign tick  = TICK_W'(clk_period_q) << prescale_shift(k_q);
	assign reach = target_q >> TIMER_BITS;

	// restoring divider, one quotient bit a cycle
	assign rem_sh   = {rem_q, dvd_q[TARGET_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, tick});
	assign rem_diff = rem_sh - {1'b0, tick};

	// remainder is the lower error, tick minus remainder the upper one
	assign err_up     = tick - rem_q;
	assign pick_upper = (err_up <= rem_q);
	assign err        = pick_upper ? err_up : rem_q;
	assign limit      = target_q >> ERROR_SHIFT;
	assign chosen     = pick_upper ? quo_q[PR_W-1:0] : (quo_q[PR_W-1:0] - PR_W'(1));

	assign sts.fits     = (reach < TARGET_W'(tick));
	assign sts.last_k   = (k_q == IDX_W'(NUM_PRESCALER - 1));
	assign sts.div_last = (cnt_q == '0);
	assign sts.accept   = (TARGET_W'(err) < limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_period_q <= CLK_PERIOD_RESET;
			k_q          <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				clk_period_q <= cfg_data;
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (cmd.div_start) begin
				cnt_q <= CNT_W'(TARGET_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= {desired_period_ns, FRAC_BITS'(0)};
		end
		if (cmd.div_start) begin
			dvd_q <= target_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_ge ? rem_diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
			quo_q <= {quo_q[TARGET_W-2:0], rem_ge};
		end
		if (cmd.finish) begin
			status_q <= cmd.code;
			if (cmd.code == STATUS_OK) begin
				index_q  <= k_q;
				period_q <= chosen;
			end else begin
				index_q  <= '0;
				period_q <= '0;
			end
		end
	end

	assign status          = status_q;
	assign prescale_idx    = index_q;
	assign period_register = period_q;

endmodule

// ===== rtl/core/timer_prescaler_period_solver_core.sv =====
// timer prescaler and period register solver
//
// request channel: drive desired_period_ns and pulse start; the request is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the answer has been produced.
// result channel: done is high for exactly one cycle with status,
// prescale_idx and period_register; the receiver cannot stall it and
// must take the result in that cycle. on a failure status the index and
// period register read zero.
// config channel: cfg_valid/cfg_ready/cfg_data writes the clock period
// (ns, 4 fraction bits); cfg_ready is always high. write only while idle.
// from the accepting edge, each prescaler is checked for reach in turn
// (up to 8), then each trial prescaler runs the 32-step shared restoring
// divider plus one error check; the longest run is when the first
// prescaler fits and all eight are tried.
// the divider sets the pace. one request is worked at a time; busy drops
// in the cycle done is shown, so the next request can be taken at the
// edge ending that cycle.
// reset: clock period returns to 200 (12.5 ns), controller goes idle.
module timer_prescaler_period_solver_core #(
	parameter int TIMER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [tpps_pkg::REQ_W-1:0]    desired_period_ns,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpps_pkg::CLK_W-1:0]    cfg_data,
	// result
	output logic                          done,
	output logic [1:0]                    status,
	output logic [tpps_pkg::IDX_W-1:0]    prescale_idx,
	output logic [tpps_pkg::PR_W-1:0]     period_register
);
	import tpps_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    cfg_we;

	// config register always accepts a write
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// sequencer: scan, divide, check error, next prescaler
	tpps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// clock period register, shared divider, error check, result registers
	tpps_dp #(
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.desired_period_ns (desired_period_ns),
		.status            (status),
		.prescale_idx      (prescale_idx),
		.period_register   (period_register)
	);

	// the result strobe never overlaps a request in flight
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted request keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// failures carry zero index and period register
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (prescale_idx == '0 && period_register == '0))
		else $error("failure result with nonzero fields");

	// no result without a request having been taken
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding work");

endmodule
